// ===== hdl/ael_pkg.sv =====
// Shared types and constants for the arithmetic expression lexer.
package ael_pkg;

  localparam int unsigned MantissaBitsDef      = 48;
  localparam int unsigned FractionCountBitsDef = 6;
  localparam int unsigned TokenKindBits        = 4;
  localparam int unsigned CharBits             = 8;

  localparam logic [CharBits-1:0] ChNul    = 8'h00;
  localparam logic [CharBits-1:0] ChTab    = 8'h09;
  localparam logic [CharBits-1:0] ChNl     = 8'h0a;
  localparam logic [CharBits-1:0] ChSpace  = 8'h20;
  localparam logic [CharBits-1:0] ChZero   = 8'h30;
  localparam logic [CharBits-1:0] ChNine   = 8'h39;
  localparam logic [CharBits-1:0] ChPoint  = 8'h2e;
  localparam logic [CharBits-1:0] ChPlus   = 8'h2b;
  localparam logic [CharBits-1:0] ChMinus  = 8'h2d;
  localparam logic [CharBits-1:0] ChStar   = 8'h2a;
  localparam logic [CharBits-1:0] ChSlash  = 8'h2f;
  localparam logic [CharBits-1:0] ChLParen = 8'h28;
  localparam logic [CharBits-1:0] ChRParen = 8'h29;

  typedef enum logic [TokenKindBits-1:0] {
    TK_NUM     = 4'd0,
    TK_ADD     = 4'd1,
    TK_SUB     = 4'd2,
    TK_MUL     = 4'd3,
    TK_DIV     = 4'd4,
    TK_LPAREN  = 4'd5,
    TK_RPAREN  = 4'd6,
    TK_ILLEGAL = 4'd7,
    TK_END     = 4'd8
  } token_kind_e;

  typedef struct packed {
    logic [1:0]  count;
    logic        has_num;
    token_kind_e k0;
    token_kind_e k1;
    token_kind_e k2;
  } grp_t;

endpackage

// ===== hdl/ael_scan.sv =====
// Per-character number state and token group decode.
module ael_scan #(
  parameter int unsigned MantissaBits      = ael_pkg::MantissaBitsDef,
  parameter int unsigned FractionCountBits = ael_pkg::FractionCountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [ael_pkg::CharBits-1:0] char_i,
  input  logic                         last_i,
  output ael_pkg::grp_t                grp_o,
  output logic [MantissaBits-1:0]      mant_o,
  output logic [FractionCountBits-1:0] frac_o,
  output logic                         ovf_o
);

  localparam logic [MantissaBits-1:0]      MantMax = {MantissaBits{1'b1}};
  localparam logic [FractionCountBits-1:0] FracMax = {FractionCountBits{1'b1}};

  logic                         in_q, in_d;
  logic [MantissaBits-1:0]      mant_q, mant_d;
  logic [FractionCountBits-1:0] frac_q, frac_d;
  logic                         pt_q, pt_d;
  logic                         ovf_q, ovf_d;

  logic                         is_digit, is_point, is_ws, is_last, is_op, end_now, num_emit;
  ael_pkg::token_kind_e         op_kind;
  logic [MantissaBits-1:0]      b_mant, a_mant;
  logic [FractionCountBits-1:0] b_frac, a_frac;
  logic                         b_pt, b_ovf, a_in, a_pt, a_ovf, skip, wide_ovf;
  logic [MantissaBits+3:0]      wide;

  always_comb begin
    is_digit = (char_i >= ael_pkg::ChZero) && (char_i <= ael_pkg::ChNine);
    is_point = char_i == ael_pkg::ChPoint;
    is_ws    = (char_i == ael_pkg::ChNul) || (char_i == ael_pkg::ChSpace) ||
               (char_i == ael_pkg::ChNl) || (char_i == ael_pkg::ChTab);
    is_last  = last_i || (char_i == ael_pkg::ChNul);
    is_op    = !is_digit && !is_point && !is_ws;
    unique case (char_i)
      ael_pkg::ChPlus:   op_kind = ael_pkg::TK_ADD;
      ael_pkg::ChMinus:  op_kind = ael_pkg::TK_SUB;
      ael_pkg::ChStar:   op_kind = ael_pkg::TK_MUL;
      ael_pkg::ChSlash:  op_kind = ael_pkg::TK_DIV;
      ael_pkg::ChLParen: op_kind = ael_pkg::TK_LPAREN;
      ael_pkg::ChRParen: op_kind = ael_pkg::TK_RPAREN;
      default:           op_kind = ael_pkg::TK_ILLEGAL;
    endcase

    b_mant = in_q ? mant_q : '0;
    b_frac = in_q ? frac_q : '0;
    b_pt   = in_q && pt_q;
    b_ovf  = in_q && ovf_q;

    skip     = b_pt && (b_frac == FracMax);
    wide     = {1'b0, b_mant, 3'b000} + {3'b000, b_mant, 1'b0} +
               {{MantissaBits{1'b0}}, char_i[3:0]};
    wide_ovf = b_ovf || (wide[MantissaBits+3:MantissaBits] != 4'd0);

    a_in   = 1'b0;
    a_mant = '0;
    a_frac = '0;
    a_pt   = 1'b0;
    a_ovf  = 1'b0;
    priority if (is_digit) begin
      a_in = 1'b1;
      a_pt = b_pt;
      if (skip) begin
        a_mant = b_mant;
        a_frac = b_frac;
        a_ovf  = b_ovf;
      end else begin
        a_mant = wide_ovf ? MantMax : wide[MantissaBits-1:0];
        a_frac = b_pt ? b_frac + 1'b1 : b_frac;
        a_ovf  = wide_ovf;
      end
    end else if (is_point && !(in_q && pt_q)) begin
      a_in   = 1'b1;
      a_pt   = 1'b1;
      a_mant = b_mant;
      a_frac = b_frac;
      a_ovf  = b_ovf;
    end else begin
      a_in = 1'b0;
    end

    end_now  = in_q && !is_digit && !(is_point && !pt_q);
    num_emit = end_now || (is_last && a_in);
    mant_o   = end_now ? mant_q : a_mant;
    frac_o   = end_now ? frac_q : a_frac;
    ovf_o    = end_now ? ovf_q : a_ovf;

    grp_o.has_num = num_emit;
    grp_o.count   = 2'({1'b0, num_emit} + {1'b0, is_op} + {1'b0, is_last});
    grp_o.k0      = num_emit ? ael_pkg::TK_NUM : (is_op ? op_kind : ael_pkg::TK_END);
    grp_o.k1      = (num_emit && is_op) ? op_kind : ael_pkg::TK_END;
    grp_o.k2      = ael_pkg::TK_END;

    in_d   = is_last ? 1'b0 : a_in;
    mant_d = is_last ? '0 : a_mant;
    frac_d = is_last ? '0 : a_frac;
    pt_d   = is_last ? 1'b0 : a_pt;
    ovf_d  = is_last ? 1'b0 : a_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q   <= 1'b0;
      mant_q <= '0;
      frac_q <= '0;
      pt_q   <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      in_q   <= in_d;
      mant_q <= mant_d;
      frac_q <= frac_d;
      pt_q   <= pt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== hdl/arithmetic_expression_lexer_unit.sv =====
// Top level of the arithmetic expression lexer.
// Usage:
//   The slave stream takes one text byte per transfer: tdata holds the byte,
//   tlast marks the final byte of an expression (a zero byte acts the same).
//   The master stream gives tokens in order: number, operator or illegal
//   byte, end. tlast marks the final token caused by one byte.
//   Whitespace bytes cause no token of their own.
// Path: a byte is registered in the input register, then decoded into a token
//   group of zero to three tokens that the output register holds.
// Throughput: one byte per cycle while each byte causes at most one token
//   and tready stays high; a byte that causes more tokens holds the input
//   while the single output register drains the group one token a cycle.
// Reset: clears the number state, the input register's valid flag and the token group;
//   the next byte starts a new expression.
// Stall: while the receiver holds tready low the current token stays on the
//   master port and one further byte waits in the input register.
module arithmetic_expression_lexer_unit #(
  parameter int unsigned MantissaBits      = ael_pkg::MantissaBitsDef,
  parameter int unsigned FractionCountBits = ael_pkg::FractionCountBitsDef,
  localparam int unsigned OutBits = ael_pkg::TokenKindBits + MantissaBits +
                                    FractionCountBits + 1,
  localparam int unsigned OutDataBits = ((OutBits + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ael_pkg::CharBits-1:0] s_axis_tdata,  // char_code
  input  logic                         s_axis_tlast,  // end_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // token_kind, mantissa, fraction_digits, mantissa_overflow, zero fill
  output logic [OutDataBits-1:0]       m_axis_tdata,
  output logic                         m_axis_tlast   // run_last
);

  logic                         in_vld_q;
  logic [ael_pkg::CharBits-1:0] in_char_q;
  logic                         in_last_q;

  ael_pkg::grp_t                grp_d, grp_q;
  logic                         grp_vld_q;
  logic [1:0]                   idx_q;
  logic [MantissaBits-1:0]      mant_d, mant_q;
  logic [FractionCountBits-1:0] frac_d, frac_q;
  logic                         ovf_d, ovf_q;

  logic                         tok_last, grp_free, step;
  ael_pkg::token_kind_e         kind;
  logic                         is_num;

  ael_scan #(
    .MantissaBits     (MantissaBits),
    .FractionCountBits(FractionCountBits)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .char_i(in_char_q),
    .last_i(in_last_q),
    .grp_o (grp_d),
    .mant_o(mant_d),
    .frac_o(frac_d),
    .ovf_o (ovf_d)
  );

  always_comb begin
    tok_last      = idx_q == (grp_q.count - 2'd1);
    grp_free      = !grp_vld_q || (m_axis_tready && tok_last);
    step          = in_vld_q && grp_free;
    s_axis_tready = !in_vld_q || step;
    unique case (idx_q)
      2'd0:    kind = grp_q.k0;
      2'd1:    kind = grp_q.k1;
      default: kind = grp_q.k2;
    endcase
    is_num        = kind == ael_pkg::TK_NUM;
    m_axis_tvalid = grp_vld_q;
    m_axis_tlast  = tok_last;
    m_axis_tdata  = OutDataBits'({(is_num && ovf_q),
                                  (is_num ? frac_q : {FractionCountBits{1'b0}}),
                                  (is_num ? mant_q : {MantissaBits{1'b0}}),
                                  kind});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      grp_vld_q <= 1'b0;
      idx_q     <= 2'd0;
      grp_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (step) begin
        grp_vld_q <= grp_d.count != 2'd0;
        grp_q     <= grp_d;
        idx_q     <= 2'd0;
      end else if (grp_vld_q && m_axis_tready) begin
        if (tok_last) begin
          grp_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (step) begin
      mant_q <= mant_d;
      frac_q <= frac_d;
      ovf_q  <= ovf_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_vld_q |-> (grp_q.count != 2'd0) && (idx_q < grp_q.count))
    else $error("token index outside group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == ael_pkg::TK_END) |-> m_axis_tlast)
    else $error("end token not last of its group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !is_num |-> (m_axis_tdata[OutBits-1:ael_pkg::TokenKindBits] == '0))
    else $error("non-number token carries a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && is_num |-> (idx_q == 2'd0) && grp_q.has_num)
    else $error("number token out of place");

endmodule
